[rtl/core/azvl_pkg.sv]
// ---------------------------------------------------------------------------
// azvl_pkg - shared types and constants
// Register indexes, zone codes, smoother coefficients and the command and
// status words between the controller and the datapath.
// ---------------------------------------------------------------------------
package azvl_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SPAN_WIDTH = 3'd0;
  localparam cfg_idx_t REG_TRANS_WIDTH = 3'd1;
  localparam cfg_idx_t REG_INSIDE_VOLT = 3'd2;
  localparam cfg_idx_t REG_OUTSIDE_VOLT = 3'd3;
  localparam cfg_idx_t REG_CURVE_SPLIT = 3'd4;

  localparam int SPAN_W = 13;
  localparam int TRANS_W = 12;
  localparam int MV_W = 16;
  localparam int SPLIT_W = 8;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 13'd1707;
  localparam logic [TRANS_W-1:0] TRANS_RESET = 12'd114;
  localparam logic [MV_W-1:0] INSIDE_RESET = 16'd500;
  localparam logic [MV_W-1:0] OUTSIDE_RESET = 16'd3000;
  localparam logic [SPLIT_W-1:0] SPLIT_RESET = 8'd77;

  localparam logic [SPLIT_W-1:0] SPLIT_MIN = 8'd26;
  localparam logic [SPLIT_W-1:0] SPLIT_MAX = 8'd230;

  typedef logic [1:0] zone_t;
  localparam zone_t ZONE_INSIDE = 2'd0;
  localparam zone_t ZONE_TRANS = 2'd1;
  localparam zone_t ZONE_OUTSIDE = 2'd2;
  localparam zone_t ZONE_IDLE = 2'd3;

  // smoother: s = (ALPHA*new + BETA*s + 2^15) >> 16
  localparam logic [11:0] ALPHA_Q16 = 12'd3277;
  localparam logic [15:0] BETA_Q16 = 16'd62259;
  localparam int STEP_MV = 5;

  // numerator factor and divisor width of the curve fraction
  localparam int FRAC_W = 24;

  typedef struct packed {
    logic load_in;
    logic eval_zone;
    logic mul_split;
    logic prep_frac;
    logic mul_num;
    logic div_start;
    logic take_curve;
    logic smooth_a;
    logic smooth_b;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic in_curve;
    logic div_done;
    logic primed;
  } sts_t;

endpackage

[rtl/core/azvl_div.sv]
// ---------------------------------------------------------------------------
// azvl_div - iterative divider
// Restoring division, one quotient bit per cycle. The numerator's upper part
// must be below the divisor so that the quotient fits in QW bits.
// ---------------------------------------------------------------------------
module azvl_div #(
  parameter int QW = 24,
  parameter int DW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo,
  output logic             done
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [QW-1:0]    qsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem, qsh[QW-1]};
  assign ge = trial >= {1'b0, dsr};
  assign quo = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= CNT_W'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[QW+DW-1:QW];
      qsh <= num[QW-1:0];
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      qsh <= {qsh[QW-2:0], ge};
    end
  end

endmodule

[rtl/core/azvl_dp.sv]
// ---------------------------------------------------------------------------
// azvl_dp - limiter datapath
// Config registers, error wrap and zone sort, transition curve with its
// divider, smoother, apply threshold and the output word register.
// ---------------------------------------------------------------------------
module azvl_dp #(
  parameter int ANGLE_BITS = 12,
  parameter int VOLT_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  azvl_pkg::cmd_t              cmd,
  output azvl_pkg::sts_t              sts,
  input  logic                        cfg_we,
  input  azvl_pkg::cfg_idx_t          cfg_index,
  input  logic [azvl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                        in_active,
  input  logic [ANGLE_BITS-1:0]       in_target,
  input  logic [ANGLE_BITS-1:0]       in_measured,
  output logic [azvl_pkg::MV_W-1:0]   out_volt,
  output logic                        out_updated,
  output azvl_pkg::zone_t             out_zone
);

  import azvl_pkg::*;

  localparam int VW = MV_W + VOLT_FRAC_BITS;
  localparam int CW = (ANGLE_BITS + 1 > SPAN_W + 1) ? ANGLE_BITS + 1 : SPAN_W + 1;
  localparam int DDW = TRANS_W + 1;
  localparam int RW = SPLIT_W + DDW;
  localparam int NW = VW + FRAC_W;
  localparam int PW = VW + 12;
  localparam int SW = VW + 17;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [VW-1:0] STEP = VW'(STEP_MV) << VOLT_FRAC_BITS;
  localparam logic [SW-1:0] ROUND_HALF = SW'(1) << 15;

  logic [SPAN_W-1:0]     span_width;
  logic [TRANS_W-1:0]    transition_width;
  logic [MV_W-1:0]       inside_voltage;
  logic [MV_W-1:0]       outside_voltage;
  logic [SPLIT_W-1:0]    curve_split;

  logic                  act;
  logic [ANGLE_BITS-1:0] tgt;
  logic [ANGLE_BITS-1:0] meas;
  zone_t                 zone;
  logic                  updated;
  logic [DDW-1:0]        d;
  logic [RW-1:0]         rdd;
  logic [FRAC_W-1:0]     frac_n;
  logic [FRAC_W-1:0]     frac_d;
  logic [NW-1:0]         num;
  logic [VW-1:0]         nv;
  logic [PW-1:0]         prod;
  logic [VW-1:0]         smoothed;
  logic                  primed;
  logic [VW-1:0]         applied;
  logic                  applied_valid;

  logic [ANGLE_BITS-1:0] err;
  logic [ANGLE_BITS-1:0] efold;
  logic [CW-1:0]         e2;
  logic [CW-1:0]         sb;
  logic [CW-1:0]         tb;
  zone_t                 zone_c;
  logic [DDW-1:0]        dd;
  logic [SPLIT_W-1:0]    rc;
  logic [VW-1:0]         vi;
  logic [VW-1:0]         vo;
  logic                  rising;
  logic [VW-1:0]         mag;
  logic [RW+2:0]         d256;
  logic [RW+2:0]         dd256;
  logic [RW+2:0]         rdd_x;
  logic                  seg1;
  logic [RW+2:0]         lo;
  logic [RW+2:0]         sel;
  logic [VW-1:0]         quo;
  logic [VW-1:0]         off;
  logic [SW-1:0]         sum;
  logic [VW-1:0]         diff;

  // zone sort
  assign err = tgt - meas;
  assign efold = (err > HALF_TURN) ? ANGLE_BITS'(-err) : err;
  assign e2 = CW'({efold, 1'b0});
  assign sb = CW'(span_width);
  assign dd = {transition_width, 1'b0};
  assign tb = CW'(span_width) + CW'(dd);

  always_comb begin
    if (e2 <= sb) begin
      zone_c = ZONE_INSIDE;
    end else if (e2 <= tb) begin
      zone_c = ZONE_TRANS;
    end else begin
      zone_c = ZONE_OUTSIDE;
    end
  end

  // curve terms
  assign rc = (curve_split < SPLIT_MIN) ? SPLIT_MIN :
              (curve_split > SPLIT_MAX) ? SPLIT_MAX : curve_split;
  assign vi = {inside_voltage, VOLT_FRAC_BITS'(0)};
  assign vo = {outside_voltage, VOLT_FRAC_BITS'(0)};
  assign rising = vo >= vi;
  assign mag = rising ? vo - vi : vi - vo;

  assign d256 = (RW + 3)'({d, 8'h00});
  assign dd256 = (RW + 3)'({dd, 8'h00});
  assign rdd_x = (RW + 3)'(rdd);
  assign seg1 = d256 <= rdd_x;
  assign lo = dd256 - rdd_x;
  assign sel = seg1 ? rdd_x : lo;

  assign off = (quo > mag) ? mag : quo;

  assign sum = SW'(prod) + SW'(smoothed) * SW'(BETA_Q16) + ROUND_HALF;
  assign diff = (smoothed >= applied) ? smoothed - applied : applied - smoothed;

  assign sts.active = act;
  assign sts.in_curve = (zone_c == ZONE_TRANS);
  assign sts.primed = primed;

  azvl_div #(
    .QW(VW),
    .DW(FRAC_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (num),
    .den  (frac_d),
    .quo  (quo),
    .done (sts.div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      span_width <= SPAN_RESET;
      transition_width <= TRANS_RESET;
      inside_voltage <= INSIDE_RESET;
      outside_voltage <= OUTSIDE_RESET;
      curve_split <= SPLIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAN_WIDTH: span_width <= cfg_data[SPAN_W-1:0];
        REG_TRANS_WIDTH: transition_width <= cfg_data[TRANS_W-1:0];
        REG_INSIDE_VOLT: inside_voltage <= cfg_data[MV_W-1:0];
        REG_OUTSIDE_VOLT: outside_voltage <= cfg_data[MV_W-1:0];
        REG_CURVE_SPLIT: curve_split <= cfg_data[SPLIT_W-1:0];
        default: ;
      endcase
    end
  end

  // limiter state
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      primed <= 1'b0;
      applied <= '0;
      applied_valid <= 1'b0;
    end else begin
      if (cmd.smooth_a && !primed) begin
        smoothed <= nv;
        primed <= 1'b1;
      end
      if (cmd.smooth_b) begin
        smoothed <= sum[VW+15:16];
      end
      if (cmd.apply && (!applied_valid || diff > STEP)) begin
        applied <= smoothed;
        applied_valid <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act <= in_active;
      tgt <= in_target;
      meas <= in_measured;
      zone <= ZONE_IDLE;
      updated <= 1'b0;
    end
    if (cmd.eval_zone) begin
      zone <= zone_c;
      d <= DDW'(e2 - sb);
      nv <= (zone_c == ZONE_INSIDE) ? vi : vo;
    end
    if (cmd.mul_split) begin
      rdd <= RW'(rc) * RW'(dd);
    end
    if (cmd.prep_frac) begin
      frac_n <= seg1 ? FRAC_W'(d256) : FRAC_W'(lo) + FRAC_W'({d256 - rdd_x, 2'b00});
      frac_d <= FRAC_W'({sel, 2'b00}) + FRAC_W'(sel);
    end
    if (cmd.mul_num) begin
      num <= NW'(mag) * NW'(frac_n) + NW'(frac_d[FRAC_W-1:1]);
    end
    if (cmd.take_curve) begin
      nv <= rising ? vi + off : vi - off;
    end
    if (cmd.smooth_a) begin
      prod <= PW'(nv) * PW'(ALPHA_Q16);
    end
    if (cmd.apply && (!applied_valid || diff > STEP)) begin
      updated <= 1'b1;
    end
    if (cmd.emit) begin
      out_volt <= applied[VW-1:VOLT_FRAC_BITS];
      out_updated <= updated;
      out_zone <= zone;
    end
  end

endmodule

[rtl/core/azvl_ctrl.sv]
// ---------------------------------------------------------------------------
// azvl_ctrl - limiter sequencer
// Steps one tick through zone sort, curve, smoother and apply, and owns the
// input and output handshakes.
// ---------------------------------------------------------------------------
module azvl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output azvl_pkg::cmd_t cmd,
  input  azvl_pkg::sts_t sts
);

  import azvl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ZONE = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_FRAC = 4'd3;
  localparam logic [3:0] S_NUM = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_CURVE = 4'd7;
  localparam logic [3:0] S_SMA = 4'd8;
  localparam logic [3:0] S_SMB = 4'd9;
  localparam logic [3:0] S_APPLY = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_ZONE;
        end
      end
      S_ZONE: begin
        cmd.eval_zone = sts.active;
        if (!sts.active) begin
          state_next = S_EMIT;
        end else if (sts.in_curve) begin
          state_next = S_SPLIT;
        end else begin
          state_next = S_SMA;
        end
      end
      S_SPLIT: begin
        cmd.mul_split = 1'b1;
        state_next = S_FRAC;
      end
      S_FRAC: begin
        cmd.prep_frac = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.mul_num = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          state_next = S_CURVE;
        end
      end
      S_CURVE: begin
        cmd.take_curve = 1'b1;
        state_next = S_SMA;
      end
      S_SMA: begin
        cmd.smooth_a = 1'b1;
        state_next = sts.primed ? S_SMB : S_APPLY;
      end
      S_SMB: begin
        cmd.smooth_b = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/angle_zone_voltage_limiter.sv]
// ---------------------------------------------------------------------------
// angle_zone_voltage_limiter - angle-error driven voltage limit
// Wraps the angle error, sorts it into inside / transition / outside zones,
// shapes the limit over the transition zone, smooths it and applies it when
// it moves by more than 5 mV.
//
//   channel  signals                               role
//   s_       tvalid tready tdata tuser             tick words in
//   m_       tvalid tready tdata tuser             limit words out
//   cfg_     valid ready index data                register writes
//
// An inactive tick goes straight to the output step. Inside and outside zones
// skip the curve, and the smoother blend step runs only once the smoother is
// primed. The transition zone forms the curve offset with the bit-serial
// divider (one quotient bit per cycle, 16 + VOLT_FRAC_BITS bits).
// One tick is worked at a time; the output register holds a finished word
// while the next tick is taken, and a stalled m_ side holds the sequencer
// in its last step. Reset loads the register defaults and clears the
// smoother and the applied limit; no clearing pass.
// ---------------------------------------------------------------------------
module angle_zone_voltage_limiter #(
  parameter int ANGLE_BITS = 12,
  parameter int VOLT_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // set angle, sensor angle
  input  logic [((2*ANGLE_BITS+7)/8)*8-1:0]   s_tdata,
  // active
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // applied limit, mV
  output logic [azvl_pkg::MV_W-1:0]           m_tdata,
  // limit_updated, zone
  output logic [2:0]                          m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  azvl_pkg::cfg_idx_t                  cfg_index,
  input  logic [azvl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import azvl_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  logic  out_updated;
  zone_t out_zone;

  assign cfg_ready = 1'b1;
  assign m_tuser = {out_zone, out_updated};

  azvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  azvl_dp #(
    .ANGLE_BITS    (ANGLE_BITS),
    .VOLT_FRAC_BITS(VOLT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_active  (s_tuser),
    .in_target  (s_tdata[ANGLE_BITS-1:0]),
    .in_measured(s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .out_volt   (m_tdata),
    .out_updated(out_updated),
    .out_zone   (out_zone)
  );

endmodule

[dv/angle_zone_voltage_limiter_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// angle_zone_voltage_limiter_tb - self-checking bench for the voltage limiter
// Drives tick words with random gaps and a randomly stalled limit sink.
// A predictor (zone sort, shaped curve, smoother and 5 mV
// deadband) queues the expected limit word for each accepted tick; the sink
// compares every word field by field. Directed ticks cover zone edges,
// wrap-round, falling curves, split clamping and a zero-width transition.
// Random phases then cover register extremes and random settings.
// ---------------------------------------------------------------------------
module angle_zone_voltage_limiter_tb;
  import azvl_pkg::*;

  localparam int ANG_W = 12;
  localparam int FRAC = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int TICKS_PER_PHASE = 106;

  typedef enum {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  typedef struct packed {
    logic [MV_W-1:0] volt;
    logic            updated;
    zone_t           zone;
  } limit_word_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [MV_W-1:0]       m_tdata;
  logic [2:0]            m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [SPAN_W-1:0]  cfg_span = SPAN_RESET;
  logic [TRANS_W-1:0] cfg_trans = TRANS_RESET;
  logic [MV_W-1:0]    cfg_inside = INSIDE_RESET;
  logic [MV_W-1:0]    cfg_outside = OUTSIDE_RESET;
  logic [SPLIT_W-1:0] cfg_split = SPLIT_RESET;
  longint unsigned    smooth_q8 = 0;
  bit                 smooth_primed = 0;
  longint unsigned    applied_q8 = 0;
  bit                 applied_valid = 0;

  limit_word_t expected_limits[$];
  idle_mode_t  send_mode = IDLE_FULL;
  idle_mode_t  recv_mode = IDLE_FULL;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  angle_zone_voltage_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("angle_zone_voltage_limiter test failed");
      $finish;
    end
  end

  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 13);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  // zone sort, curve, smoother and deadband for one tick; updates state
  function automatic limit_word_t predict_limit(bit act, bit [ANG_W-1:0] tgt,
                                                bit [ANG_W-1:0] meas);
    limit_word_t w;
    bit [ANG_W-1:0] diff_ang;
    longint unsigned err, e2, sb, tb, nv, r, vi, vo, mag, off, d, dd, num, den, gap;
    bit rising;
    w.updated = 1'b0;
    w.zone = ZONE_IDLE;
    if (act) begin
      diff_ang = tgt - meas;
      err = diff_ang;
      if (err > (1 << (ANG_W - 1))) err = (1 << ANG_W) - err;
      e2 = 2 * err;
      sb = cfg_span;
      dd = 2 * longint'(cfg_trans);
      tb = sb + dd;
      vi = cfg_inside;
      vi = vi << FRAC;
      vo = cfg_outside;
      vo = vo << FRAC;
      if (e2 <= sb) begin
        w.zone = ZONE_INSIDE;
        nv = vi;
      end else if (e2 <= tb) begin
        w.zone = ZONE_TRANS;
        r = cfg_split;
        if (r < SPLIT_MIN) r = SPLIT_MIN;
        if (r > SPLIT_MAX) r = SPLIT_MAX;
        rising = vo >= vi;
        mag = rising ? vo - vi : vi - vo;
        d = e2 - sb;
        // gentle segment gives 20% of the rise, steep segment the other 80%
        if (d * 256 <= r * dd) begin
          den = 5 * r * dd;
          off = (mag * 256 * d + den / 2) / den;
        end else begin
          num = (256 - r) * dd + 4 * (256 * d - r * dd);
          den = 5 * (256 - r) * dd;
          off = (mag * num + den / 2) / den;
        end
        if (off > mag) off = mag;
        nv = rising ? vi + off : vi - off;
      end else begin
        w.zone = ZONE_OUTSIDE;
        nv = vo;
      end
      if (!smooth_primed) begin
        smooth_q8 = nv;
        smooth_primed = 1'b1;
      end else begin
        smooth_q8 = (ALPHA_Q16 * nv + BETA_Q16 * smooth_q8 + 32768) >> 16;
      end
      gap = (smooth_q8 >= applied_q8) ? smooth_q8 - applied_q8 : applied_q8 - smooth_q8;
      if (!applied_valid || gap > (STEP_MV << FRAC)) begin
        applied_q8 = smooth_q8;
        applied_valid = 1'b1;
        w.updated = 1'b1;
      end
    end
    w.volt = MV_W'(applied_q8 >> FRAC);
    return w;
  endfunction

  task automatic send_tick(input bit act, input bit [ANG_W-1:0] tgt,
                           input bit [ANG_W-1:0] meas);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {meas, tgt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_limits.push_back(predict_limit(act, tgt, meas));
  endtask

  task automatic send_err(input int err, input bit [ANG_W-1:0] meas);
    send_tick(1'b1, ANG_W'(int'(meas) + err), meas);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_limits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SPAN_WIDTH:   cfg_span = val[SPAN_W-1:0];
      REG_TRANS_WIDTH:  cfg_trans = val[TRANS_W-1:0];
      REG_INSIDE_VOLT:  cfg_inside = val[MV_W-1:0];
      REG_OUTSIDE_VOLT: cfg_outside = val[MV_W-1:0];
      REG_CURVE_SPLIT:  cfg_split = val[SPLIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int span, input int trans, input int vin,
                               input int vout, input int split);
    wait_idle();
    write_reg(REG_SPAN_WIDTH, CFG_DATA_W'(span));
    write_reg(REG_TRANS_WIDTH, CFG_DATA_W'(trans));
    write_reg(REG_INSIDE_VOLT, CFG_DATA_W'(vin));
    write_reg(REG_OUTSIDE_VOLT, CFG_DATA_W'(vout));
    write_reg(REG_CURVE_SPLIT, CFG_DATA_W'(split));
    cfg_valid <= 1'b0;
  endtask

  // inactive before anything applied, first sample, wrap-round, max error
  task automatic test_power_up();
    send_tick(1'b0, '0, '0);
    send_tick(1'b1, '0, '0);
    send_tick(1'b0, '1, '1);
    send_tick(1'b1, 12'd4095, 12'd0);
    send_tick(1'b1, 12'd2048, 12'd0);
    send_tick(1'b1, 12'd0, 12'd4095);
  endtask

  task automatic test_zone_edges();
    apply_setting(1000, 100, 500, 3000, 77);
    send_err(500, 12'd100);
    send_err(501, 12'd3);
    send_err(-550, 12'd20);
    send_err(600, 12'd4000);
    send_err(601, 12'd7);
    send_err(-500, 12'd4095);
  endtask

  task automatic test_falling_curve();
    apply_setting(1000, 100, 3000, 500, 77);
    send_err(520, 12'd1000);
    send_err(-560, 12'd300);
    send_err(600, 12'd2222);
  endtask

  task automatic test_split_clamp();
    apply_setting(1000, 100, 500, 3000, 0);
    send_err(510, 12'd50);
    send_err(530, 12'd60);
    apply_setting(1000, 100, 500, 3000, 255);
    send_err(540, 12'd70);
    send_err(590, 12'd80);
  endtask

  task automatic test_no_transition();
    apply_setting(1000, 0, 500, 3000, 77);
    send_err(500, 12'd10);
    send_err(501, 12'd10);
  endtask

  function automatic int pick_error();
    int half, e;
    half = int'(cfg_span) / 2;
    case ($urandom_range(0, 4))
      0: e = $urandom_range(0, 2048);
      1: e = half + int'($urandom_range(0, 4)) - 2;
      2: e = (int'(cfg_span) + 2 * int'(cfg_trans)) / 2 + int'($urandom_range(0, 4)) - 2;
      3: e = half + int'($urandom_range(0, int'(cfg_trans)));
      default: e = $urandom_range(0, 1) ? 0 : 2048;
    endcase
    if (e < 0) e = 0;
    if (e > 2048) e = 2048;
    return e;
  endfunction

  task automatic test_random_settings();
    bit [ANG_W-1:0] meas;
    int err;
    bit act;
    for (int k = 0; k < PHASES; k++) begin
      case (k)
        0: apply_setting(1707, 114, 500, 3000, 77);
        1: apply_setting(0, 2048, 0, 65535, 0);
        2: apply_setting(4096, 0, 65535, 65535, 255);
        3: apply_setting(8191, 4095, 65535, 0, 26);
        4: apply_setting(1200, 4095, 40000, 100, 230);
        default: apply_setting($urandom_range(0, 3000), $urandom_range(0, 2048),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 255));
      endcase
      case (k)
        0: begin send_mode = IDLE_NONE; recv_mode = IDLE_NONE; end
        1: begin send_mode = IDLE_FULL; recv_mode = IDLE_FULL; end
        2: begin send_mode = IDLE_SPARSE; recv_mode = IDLE_FULL; end
        default: begin
          send_mode = idle_mode_t'($urandom_range(0, 2));
          recv_mode = idle_mode_t'($urandom_range(0, 2));
        end
      endcase
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        meas = $urandom_range(0, 4095);
        err = pick_error();
        act = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 1)) err = -err;
        send_tick(act, ANG_W'(int'(meas) + err), meas);
      end
    end
  endtask

  // limit word sink and checker
  initial begin : limit_sink
    limit_word_t got, want;
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(recv_mode);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.volt = m_tdata;
      got.updated = m_tuser[0];
      got.zone = m_tuser[2:1];
      if (expected_limits.size() == 0) begin
        report_mismatch($sformatf("unexpected word volt %0d upd %0d zone %0d",
                                  got.volt, got.updated, got.zone));
      end else begin
        want = expected_limits.pop_front();
        if (got.volt !== want.volt)
          report_mismatch($sformatf("applied limit got %0d expected %0d",
                                    got.volt, want.volt));
        if (got.updated !== want.updated)
          report_mismatch($sformatf("limit_updated got %0d expected %0d",
                                    got.updated, want.updated));
        if (got.zone !== want.zone)
          report_mismatch($sformatf("zone got %0d expected %0d", got.zone, want.zone));
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SPAN_WIDTH;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_power_up();
    test_zone_edges();
    test_falling_curve();
    test_split_clamp();
    test_no_transition();
    test_random_settings();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("angle_zone_voltage_limiter test passed");
    end else begin
      $display("angle_zone_voltage_limiter test failed");
    end
    $finish;
  end

endmodule
